// ===== design/sia_pkg.sv =====
// Shared types and fixed field widths for the stratum id assigner.
package sia_pkg;

	// Fixed port widths
	localparam int UNIT_W   = 12;
	localparam int GID_W    = 8;
	localparam int KEY_W    = 64;
	localparam int STRAT_W  = 12;
	localparam int COUNT_W  = 13;

	// Configuration registers
	localparam int NGRP_W     = 5;
	localparam int NLANE_W    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_LANES  = 1'd1;

	localparam logic [NGRP_W-1:0]  NUM_GROUPS_RST = 5'd16;
	localparam logic [NLANE_W-1:0] NUM_LANES_RST  = 3'd4;

	// Unit counts saturate here
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_SLOT,
		S_CNT_RD,
		S_CNT_WR
	} sia_state_t;

endpackage

// ===== design/stratum_id_assigner.sv =====
// Stratum id assigner: sequential key-table search with per-stratum group counts.
//
// Pulse start while busy is low to hand over one unit; the unit is taken at that edge.
// The unit's key is compared against the keys already seen in the current first-variable
// group, one table entry per cycle through a single lane-wise compare unit fed from the
// key table's registered read port. A hit reuses the matching stratum id, a miss appends
// the key and takes the next global id while ids remain, else reuses the last id. The
// (stratum, sample group) count is then read from the count memory and, unless the
// sample group is out of range, bumped and written back. The result appears for
// exactly one cycle with done high, in the first cycle in which busy is low again, and
// cannot be held off: capture it then. A new unit may be started in that same cycle.
// After reset all MAX_UNITS * MAX_GROUPS entries of the count memory (65536 at the
// default sizes) are swept to zero, one entry a cycle; busy stays high meanwhile.
// Configuration writes are taken at any time but should only be issued while the
// block is idle.
module stratum_id_assigner
	import sia_pkg::*;
#(
	parameter int MAX_UNITS  = 4096,
	parameter int MAX_GROUPS = 16,
	parameter int KEY_LANES  = 4,
	parameter int LANE_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,

	// command side
	input  logic                   start,
	output logic                   busy,
	input  logic [UNIT_W-1:0]      unit_id,
	input  logic                   first_of_value,
	input  logic signed [GID_W-1:0] sample_group,
	input  logic [KEY_W-1:0]       key,

	// result side
	output logic                   done,
	output logic [UNIT_W-1:0]      out_unit_id,
	output logic [STRAT_W-1:0]     stratum,
	output logic                   new_stratum,
	output logic                   group_error,
	output logic [COUNT_W-1:0]     group_count
);

	localparam int ID_W     = $clog2(MAX_UNITS);
	localparam int CNT_W    = ID_W + 1;
	localparam int KEY_BITS = KEY_LANES * LANE_BITS;
	localparam int DEPTH    = MAX_UNITS * MAX_GROUPS;
	localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LIM_W    = GID_W + 1;

	sia_state_t state_q, state_d;

	// configuration
	logic [NGRP_W-1:0]  num_groups_q;
	logic [NLANE_W-1:0] num_lanes_q;

	// allocation state
	logic [CNT_W-1:0]   next_stratum_q;
	logic [ID_W-1:0]    group_base_q;
	logic [CNT_W-1:0]   entry_count_q;

	// search state
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   pend_idx_q;
	logic               pend_q;

	// latched unit
	logic [UNIT_W-1:0]  unit_q;
	logic [KEY_W-1:0]   key_q;
	logic [GID_W-1:0]   gid_q;
	logic               err_q;

	// outcome
	logic [ID_W-1:0]    id_q;
	logic               fresh_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  clr_addr_q;

	// memories
	logic [KEY_BITS-1:0] seen_keys [MAX_UNITS];
	logic [KEY_BITS-1:0] key_rd_q;
	logic [COUNT_W-1:0]  group_counts [DEPTH];
	logic [COUNT_W-1:0]  cnt_rd_q;

	// control
	logic               accept;
	logic               rd_issue;
	logic               hit;
	logic               miss;
	logic               room;
	logic               key_we;
	logic               cnt_we;
	logic               clr_we;
	logic [SLOT_W-1:0]  cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;
	logic [COUNT_W-1:0] cnt_inc;

	// compare unit
	logic [NLANE_W-1:0] lanes_eff;
	logic [KEY_LANES-1:0] lane_ok;
	logic               lane_hit;

	// group range check
	logic [LIM_W-1:0]   ngrp_ext;
	logic [LIM_W-1:0]   grp_limit;
	logic               grp_err;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign room   = (next_stratum_q < CNT_W'(MAX_UNITS));

	// Clamp lane count, then compare lanes independently; lanes past the count always pass.
	assign lanes_eff = (num_lanes_q > NLANE_W'(KEY_LANES)) ? NLANE_W'(KEY_LANES) : num_lanes_q;

	for (genvar l = 0; l < KEY_LANES; l++) begin : g_lane
		assign lane_ok[l] = (NLANE_W'(l) >= lanes_eff) ||
			(key_rd_q[l*LANE_BITS +: LANE_BITS] == key_q[l*LANE_BITS +: LANE_BITS]);
	end
	assign lane_hit = &lane_ok;

	// Negative ids and ids at or past the clamped group count are errors.
	assign ngrp_ext  = LIM_W'(num_groups_q);
	assign grp_limit = (ngrp_ext > LIM_W'(MAX_GROUPS)) ? LIM_W'(MAX_GROUPS) : ngrp_ext;
	assign grp_err   = sample_group[GID_W-1] || ({1'b0, sample_group} >= grp_limit);

	assign cnt_inc   = (cnt_rd_q == COUNT_MAX) ? cnt_rd_q : cnt_rd_q + COUNT_W'(1);
	assign cnt_waddr = clr_we ? clr_addr_q : slot_q;
	assign cnt_wdata = clr_we ? '0 : cnt_inc;
	assign key_we    = miss && room;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer controls
	always_comb begin
		state_d  = state_q;
		rd_issue = 1'b0;
		hit      = 1'b0;
		miss     = 1'b0;
		cnt_we   = 1'b0;
		clr_we   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				clr_we = 1'b1;
				if (clr_addr_q == SLOT_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				// a pending read that matches ends the search; else read on or give up
				if (pend_q && lane_hit) begin
					hit     = 1'b1;
					state_d = S_SLOT;
				end else if (idx_q < entry_count_q) begin
					rd_issue = 1'b1;
				end else if (!pend_q) begin
					miss    = 1'b1;
					state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				state_d = S_CNT_RD;
			end
			S_CNT_RD: begin
				state_d = S_CNT_WR;
			end
			S_CNT_WR: begin
				cnt_we  = !err_q;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_groups_q <= NUM_GROUPS_RST;
			num_lanes_q  <= NUM_LANES_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_NUM_GROUPS: num_groups_q <= cfg_wdata[NGRP_W-1:0];
				CFG_NUM_LANES:  num_lanes_q  <= cfg_wdata[NLANE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_stratum_q <= '0;
			group_base_q   <= '0;
			entry_count_q  <= '0;
			idx_q          <= '0;
			pend_q         <= 1'b0;
			clr_addr_q     <= '0;
			done           <= 1'b0;
		end else begin
			done <= (state_q == S_CNT_WR);
			if (clr_we) begin
				clr_addr_q <= clr_addr_q + SLOT_W'(1);
			end
			if (accept) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
				// open a new group: restart the table at the next free id
				if (first_of_value) begin
					group_base_q  <= room ? next_stratum_q[ID_W-1:0] : ID_W'(MAX_UNITS - 1);
					entry_count_q <= '0;
				end
			end else if (state_q == S_SEARCH) begin
				pend_q <= rd_issue;
				if (rd_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (key_we) begin
					entry_count_q  <= entry_count_q + CNT_W'(1);
					next_stratum_q <= next_stratum_q + CNT_W'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			unit_q <= unit_id;
			key_q  <= key;
			gid_q  <= sample_group;
			err_q  <= grp_err;
		end
		if (rd_issue) begin
			pend_idx_q <= idx_q;
		end
		if (hit) begin
			id_q    <= group_base_q + pend_idx_q[ID_W-1:0];
			fresh_q <= 1'b0;
		end else if (miss) begin
			id_q    <= room ? next_stratum_q[ID_W-1:0] : ID_W'(MAX_UNITS - 1);
			fresh_q <= room;
		end
		if (state_q == S_SLOT) begin
			slot_q <= SLOT_W'(id_q) * SLOT_W'(MAX_GROUPS) + SLOT_W'(gid_q);
		end
		if (state_q == S_CNT_WR) begin
			out_unit_id <= unit_q;
			stratum     <= STRAT_W'(id_q);
			new_stratum <= fresh_q;
			group_error <= err_q;
			group_count <= err_q ? '0 : cnt_inc;
		end
	end

	// key table
	always_ff @(posedge clk) begin
		if (key_we) begin
			seen_keys[entry_count_q[ID_W-1:0]] <= key_q[KEY_BITS-1:0];
		end
		key_rd_q <= seen_keys[idx_q[ID_W-1:0]];
	end

	// count memory
	always_ff @(posedge clk) begin
		if (cnt_we || clr_we) begin
			group_counts[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= group_counts[slot_q];
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stratum id assigner: unit beats checked against a predictor.
module tb;
	import sia_pkg::*;

	localparam int N_UNITS      = 4096;
	localparam int N_GROUPS     = 16;
	localparam int N_LANES      = 4;
	localparam int LANE_W       = 16;
	localparam int CNT_SLOTS    = N_UNITS * N_GROUPS;
	localparam int LIMIT_CYCLES = 2_000_000;

	// One unit handed to the block, and the stratum result it must produce
	typedef struct {
		logic [UNIT_W-1:0]       unit;
		logic                    first;
		logic signed [GID_W-1:0] gid;
		logic [KEY_W-1:0]        key;
	} unit_beat_t;

	typedef struct {
		logic [UNIT_W-1:0]  unit;
		logic [STRAT_W-1:0] stratum;
		logic               fresh;
		logic               gerr;
		logic [COUNT_W-1:0] count;
	} stratum_beat_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_addr       = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata      = '0;
	logic                    start          = 1'b0;
	logic                    busy;
	logic [UNIT_W-1:0]       unit_id        = '0;
	logic                    first_of_value = 1'b0;
	logic signed [GID_W-1:0] sample_group   = '0;
	logic [KEY_W-1:0]        key            = '0;
	logic                    done;
	logic [UNIT_W-1:0]       out_unit_id;
	logic [STRAT_W-1:0]      stratum;
	logic                    new_stratum;
	logic                    group_error;
	logic [COUNT_W-1:0]      group_count;

	stratum_id_assigner #(
		.MAX_UNITS (N_UNITS),
		.MAX_GROUPS(N_GROUPS),
		.KEY_LANES (N_LANES),
		.LANE_BITS (LANE_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.unit_id       (unit_id),
		.first_of_value(first_of_value),
		.sample_group  (sample_group),
		.key           (key),
		.done          (done),
		.out_unit_id   (out_unit_id),
		.stratum       (stratum),
		.new_stratum   (new_stratum),
		.group_error   (group_error),
		.group_count   (group_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the configuration and of the block's state
	bit [NGRP_W-1:0]  ngroups_cfg = NUM_GROUPS_RST;
	bit [NLANE_W-1:0] lanes_cfg   = NUM_LANES_RST;
	bit [12:0]        next_id;
	bit [11:0]        tbl_base;
	bit [12:0]        tbl_fill;
	bit [KEY_W-1:0]   seen_tab [N_UNITS];
	bit [COUNT_W-1:0] unit_tally [CNT_SLOTS];

	unit_beat_t    unit_queue [$];   // beats waiting for the driver
	stratum_beat_t strata_due [$];   // results owed by the block, oldest first
	int            gap_pct     = 21; // chance in a hundred that the sender idles a cycle
	int            fail_count  = 0;
	int            cycle_count = 0;

	// Work out the result of one accepted unit and advance the predictor state.
	function automatic stratum_beat_t assign_stratum(input unit_beat_t u);
		stratum_beat_t r;
		bit [KEY_W-1:0] mask;
		int lanes, lim, g, id, i, slot;
		bit hit;
		bit [COUNT_W-1:0] c;
		if (u.first) begin
			// a new first-variable group: drop the table, base on the next free id
			tbl_base = (next_id < N_UNITS) ? next_id[11:0] : 12'(N_UNITS - 1);
			tbl_fill = '0;
		end
		lanes = (lanes_cfg > N_LANES) ? N_LANES : int'(lanes_cfg);
		mask  = (lanes * LANE_W >= KEY_W) ? '1 : (64'd1 << (lanes * LANE_W)) - 64'd1;
		hit   = 1'b0;
		id    = 0;
		r.fresh = 1'b0;
		for (i = 0; i < int'(tbl_fill); i++) begin
			if (((seen_tab[i] ^ u.key) & mask) == '0) begin
				id  = int'(tbl_base) + i;
				hit = 1'b1;
				break;
			end
		end
		if (!hit) begin
			if (next_id < N_UNITS && tbl_fill < N_UNITS) begin
				id = int'(next_id);
				seen_tab[tbl_fill] = u.key;
				tbl_fill++;
				next_id++;
				r.fresh = 1'b1;
			end else begin
				// ids exhausted: nothing is stored, the last id is reused
				id = N_UNITS - 1;
			end
		end
		if (id >= N_UNITS)
			id = N_UNITS - 1;
		lim    = (ngroups_cfg > N_GROUPS) ? N_GROUPS : int'(ngroups_cfg);
		g      = u.gid;
		r.gerr = (g < 0) || (g >= lim);
		c      = '0;
		if (!r.gerr) begin
			slot = id * N_GROUPS + g;
			c    = unit_tally[slot];
			if (c < COUNT_MAX)
				c++;
			unit_tally[slot] = c;
		end
		r.unit    = u.unit;
		r.stratum = id[STRAT_W-1:0];
		r.count   = c;
		return r;
	endfunction

	// Driver: present the oldest pending beat, hold it until taken, idle at random.
	always @(posedge clk) begin : drive_units
		bit taken;
		taken = start && !busy;
		if (taken) begin
			strata_due.push_back(assign_stratum(unit_queue[0]));
			unit_queue.delete(0);
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			if (unit_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
				start          <= 1'b1;
				unit_id        <= unit_queue[0].unit;
				first_of_value <= unit_queue[0].first;
				sample_group   <= unit_queue[0].gid;
				key            <= unit_queue[0].key;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
		end
	endtask

	// Monitor: every done strobe must match the oldest owed result.
	always @(posedge clk) begin : check_results
		stratum_beat_t want;
		if (arst_n && done) begin
			if (strata_due.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing owed, expected none actual unit %0h",
					$time, out_unit_id);
			end else begin
				want = strata_due[0];
				strata_due.delete(0);
				check_field("out_unit_id", 16'(want.unit), 16'(out_unit_id));
				check_field("stratum", 16'(want.stratum), 16'(stratum));
				check_field("new_stratum", 16'(want.fresh), 16'(new_stratum));
				check_field("group_error", 16'(want.gerr), 16'(group_error));
				check_field("group_count", 16'(want.count), 16'(group_count));
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("** stratum_id_assigner: FAILED **");
			$finish;
		end
	end

	task automatic push_unit(input logic [UNIT_W-1:0] u, input logic f,
			input logic signed [GID_W-1:0] g, input logic [KEY_W-1:0] k);
		unit_beat_t b;
		b.unit  = u;
		b.first = f;
		b.gid   = g;
		b.key   = k;
		unit_queue.push_back(b);
	endtask

	// Wait at a falling edge until every beat is taken, every result is in
	// and the block is idle (this also covers the clearing sweep after reset).
	task automatic settle();
		do @(negedge clk);
		while (unit_queue.size() != 0 || strata_due.size() != 0 || start || busy);
	endtask

	// Write one register; only called while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_GROUPS)
			ngroups_cfg = data[NGRP_W-1:0];
		else
			lanes_cfg = data[NLANE_W-1:0];
		@(negedge clk);
	endtask

	// Queue one first-variable group: a few keys repeated, lanes outside the
	// compare scrambled now and then, some noise keys and bad group ids.
	task automatic add_group(output int added);
		bit [KEY_W-1:0] pool [4];
		bit [KEY_W-1:0] k;
		logic signed [GID_W-1:0] g;
		int npool, len, lanes, lim, j, l;
		npool = $urandom_range(1, 4);
		for (j = 0; j < 4; j++)
			pool[j] = {$urandom, $urandom};
		len   = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		lanes = (lanes_cfg > N_LANES) ? N_LANES : int'(lanes_cfg);
		lim   = (ngroups_cfg > N_GROUPS) ? N_GROUPS : int'(ngroups_cfg);
		for (j = 0; j < len; j++) begin
			k = pool[$urandom_range(0, npool - 1)];
			if ($urandom_range(0, 3) == 0)
				for (l = lanes; l < N_LANES; l++)
					k[l*LANE_W +: LANE_W] = 16'($urandom);
			if ($urandom_range(0, 9) == 0)
				k = {$urandom, $urandom};
			if (lim == 0 || $urandom_range(0, 7) == 0)
				g = GID_W'($urandom);
			else
				g = GID_W'($urandom_range(0, lim - 1));
			// now and then leave out the group start so the previous table carries on
			push_unit(UNIT_W'($urandom), (j == 0) && ($urandom_range(0, 19) != 0), g, k);
		end
		added = len;
	endtask

	initial begin : stimulus
		int phase_ng [6];
		int phase_lanes [6];
		int n, added;
		phase_ng    = '{16, 0, 31, 1, 5, 17};
		phase_lanes = '{4, 0, 7, 1, 2, 3};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		settle();
		write_reg(CFG_NUM_GROUPS, 5'd16);
		write_reg(CFG_NUM_LANES, 5'd4);

		// Directed: first units with no group start, field extremes, lane-3-only keys
		push_unit(12'd0, 1'b0, 8'sd0, 64'd0);
		push_unit(12'd4095, 1'b0, 8'sd0, 64'd0);
		push_unit(12'h555, 1'b0, 8'sd15, '1);
		push_unit(12'haaa, 1'b0, 8'sd16, '1);
		push_unit(12'd1, 1'b0, -8'sd1, 64'h8000_0000_0000_0000);
		push_unit(12'd2, 1'b0, 8'sh80, 64'h1);
		push_unit(12'd3, 1'b0, 8'sd127, 64'h0000_0000_0001_0000);
		push_unit(12'd4, 1'b0, 8'sd7, 64'h0000_0001_0000_0000);
		push_unit(12'd5, 1'b0, 8'sd15, '1);
		push_unit(12'd6, 1'b1, 8'sd0, 64'd0);
		push_unit(12'd7, 1'b1, 8'sd0, 64'd0);
		push_unit(12'd8, 1'b0, 8'sd0, 64'd0);
		push_unit(12'd9, 1'b0, 8'sd0, 64'h8000_0000_0000_0000);
		push_unit(12'd10, 1'b0, 8'sd1, 64'h8000_0000_0000_0000);
		// pause the sender until the block has caught up
		settle();
		// zero lanes: every key matches; zero groups: every unit flagged
		write_reg(CFG_NUM_GROUPS, 5'd0);
		write_reg(CFG_NUM_LANES, 5'd0);
		push_unit(12'd11, 1'b1, 8'sd0, {$urandom, $urandom});
		push_unit(12'd12, 1'b0, 8'sd0, {$urandom, $urandom});
		push_unit(12'd13, 1'b0, 8'sh80, {$urandom, $urandom});
		push_unit(12'd14, 1'b1, 8'sd5, {$urandom, $urandom});
		settle();
		// oversized settings clamp to the table limits
		write_reg(CFG_NUM_GROUPS, 5'd31);
		write_reg(CFG_NUM_LANES, 5'd7);
		push_unit(12'd15, 1'b1, 8'sd15, 64'hFFFF_0000_0000_0000);
		push_unit(12'd16, 1'b0, 8'sd15, 64'h7FFF_0000_0000_0000);
		push_unit(12'd17, 1'b0, 8'sd16, 64'hFFFF_0000_0000_0000);

		// Random groups under a spread of settings; sender idles 21%, then 81%, then never
		for (int p = 0; p < 6; p++) begin
			settle();
			gap_pct = (p < 2) ? 21 : (p < 4) ? 81 : 0;
			write_reg(CFG_NUM_GROUPS, 5'(phase_ng[p]));
			write_reg(CFG_NUM_LANES, 5'(phase_lanes[p]));
			n = 0;
			while (n < 128) begin
				add_group(added);
				n += added;
			end
		end

		settle();
		// keep running to catch any stray result
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** stratum_id_assigner: PASSED **");
		else
			$display("** stratum_id_assigner: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
design/sia_pkg.sv
design/stratum_id_assigner.sv
tb/tb.sv
